### sv/dnf_pkg.sv
package dnf_pkg;

  localparam int SLOTS       = 4096;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int DATA_W      = 32;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 4 * COEF_W;
  localparam int NUM_W       = DATA_W + 16;
  localparam int DEN_W       = DATA_W + 1;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_COEFF_X = 2'd0;
  localparam logic [1:0] REG_COEFF_Y = 2'd1;
  localparam logic [1:0] REG_COEFF_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [DATA_W-1:0] p_now;
    logic signed [DATA_W-1:0] p_prev;
    logic signed [DATA_W-1:0] s_now;
    logic signed [DATA_W-1:0] s_prev;
  } slot_state_t;

  typedef struct packed {
    logic [NUM_W-1:0]         num_mag;
    logic [DEN_W-1:0]         den_mag;
    logic                     q_neg;
    logic                     den_zero;
    logic                     p_neg;
    logic signed [DATA_W-1:0] v;
    logic                     fault;
  } div_job_t;

  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > 64'sd2147483647) || (x < -64'sd2147483648);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return SAT_MAX;
    end else if (x < -64'sd2147483648) begin
      return SAT_MIN;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

### sv/dnf_ram.sv
module dnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/dnf_front.sv
module dnf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [dnf_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_axis,
  input  logic [11:0]                         in_slot,
  input  logic signed [dnf_pkg::DATA_W-1:0]   in_u_term,
  input  logic signed [dnf_pkg::DATA_W-1:0]   in_v_term,
  input  logic signed [dnf_pkg::DATA_W-1:0]   in_field_now,
  input  logic [dnf_pkg::QCNT_W-1:0]          q_level,
  output logic                                push,
  output dnf_pkg::div_job_t                   job
);
  import dnf_pkg::*;

  logic [CFG_W-1:0] coeff_x_r, coeff_y_r, coeff_z_r;
  logic [SLOT_W:0]  clr_cnt_r;
  logic             clr_busy;

  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic [SLOT_W-1:0] slot1_r, slot2_r, slot3_r, in_addr;
  logic hazard, credit_ok, accept;
  logic [QCNT_W:0] used;

  // stage 1
  logic [1:0] axis1_r;
  logic signed [DATA_W-1:0] u1_r, vt1_r, e1_r;
  logic signed [63:0] ee1_r;
  // stage 2
  logic signed [DATA_W-1:0] u2_r, vt2_r, e2_2_r, s_old2_r, p_old2_r;
  logic signed [COEF_W-1:0] sa3_2_r;
  logic signed [47:0] m_sn2_r, m_sp2_r, m_pn2_r, m_pp2_r, m_e2_r;
  logic fault2_r;
  // stage 3
  logic signed [DATA_W-1:0] u3_r, vt3_r, s_old3_r, p_old3_r;
  logic signed [49:0] sum_s3_r, sum_p3_r;
  logic fault3_r;
  // stage 4
  logic signed [DATA_W-1:0] u4_r, vt4_r, s4_r, p4_r;
  logic fault4_r;

  logic [CFG_W-1:0] csel;
  logic signed [COEF_W-1:0] a1, a2, a3, sa3;
  slot_state_t rd, wst;
  logic [$bits(slot_state_t)-1:0] ram_rdata, ram_wdata;
  logic ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic signed [63:0] ee_nxt, e2_sh;
  logic signed [49:0] s_rnd, p_rnd;
  logic signed [DATA_W-1:0] snext, pnext;
  logic signed [DEN_W-1:0] den;
  logic [DATA_W-1:0] p_mag;

  assign clr_busy = (clr_cnt_r != (SLOT_W+1)'(SLOTS));
  assign in_addr  = in_slot[SLOT_W-1:0];
  assign hazard   = (vld1_r && slot1_r == in_addr) || (vld2_r && slot2_r == in_addr) ||
                    (vld3_r && slot3_r == in_addr);
  assign used     = (QCNT_W+1)'(q_level) + (QCNT_W+1)'(vld1_r) + (QCNT_W+1)'(vld2_r) +
                    (QCNT_W+1)'(vld3_r) + (QCNT_W+1)'(vld4_r);
  assign credit_ok = used < (QCNT_W+1)'(QUEUE_DEPTH);
  assign in_ready  = !clr_busy && !hazard && credit_ok;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      coeff_x_r <= '0;
      coeff_y_r <= '0;
      coeff_z_r <= '0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_X: coeff_x_r <= cfg_wdata;
          REG_COEFF_Y: coeff_y_r <= cfg_wdata;
          REG_COEFF_Z: coeff_z_r <= cfg_wdata;
          default: ;
        endcase
      end
      vld1_r <= accept;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  assign ee_nxt = in_field_now * in_field_now;

  // stage 1: coefficient select, history products, E*E rounding
  assign csel = (axis1_r == AXIS_X) ? coeff_x_r :
                (axis1_r == AXIS_Y) ? coeff_y_r : coeff_z_r;
  assign a1  = csel[15:0];
  assign a2  = csel[31:16];
  assign a3  = csel[47:32];
  assign sa3 = csel[63:48];
  assign rd  = ram_rdata;
  assign e2_sh = (ee1_r + 64'sd32768) >>> 16;

  // stage 3: round and saturate the recursions
  assign s_rnd = (sum_s3_r + 50'sd4096) >>> 13;
  assign p_rnd = (sum_p3_r + 50'sd4096) >>> 13;
  assign snext = sat32(64'(s_rnd));
  assign pnext = sat32(64'(p_rnd));

  assign wst.p_now  = pnext;
  assign wst.p_prev = p_old3_r;
  assign wst.s_now  = snext;
  assign wst.s_prev = s_old3_r;
  assign ram_we    = clr_busy || vld3_r;
  assign ram_waddr = clr_busy ? clr_cnt_r[SLOT_W-1:0] : slot3_r;
  assign ram_wdata = clr_busy ? '0 : wst;

  always_ff @(posedge clk) begin
    axis1_r <= in_axis;
    slot1_r <= in_addr;
    u1_r    <= in_u_term;
    vt1_r   <= in_v_term;
    e1_r    <= in_field_now;
    ee1_r   <= ee_nxt;

    slot2_r  <= slot1_r;
    u2_r     <= u1_r;
    vt2_r    <= vt1_r;
    e2_2_r   <= sat32(e2_sh);
    fault2_r <= ovf32(e2_sh);
    sa3_2_r  <= sa3;
    s_old2_r <= rd.s_now;
    p_old2_r <= rd.p_now;
    m_sn2_r  <= a1 * rd.s_now;
    m_sp2_r  <= a2 * rd.s_prev;
    m_pn2_r  <= a1 * rd.p_now;
    m_pp2_r  <= a2 * rd.p_prev;
    m_e2_r   <= a3 * e1_r;

    slot3_r  <= slot2_r;
    u3_r     <= u2_r;
    vt3_r    <= vt2_r;
    s_old3_r <= s_old2_r;
    p_old3_r <= p_old2_r;
    fault3_r <= fault2_r;
    sum_s3_r <= m_sn2_r + m_sp2_r - 50'(sa3_2_r * e2_2_r);
    sum_p3_r <= m_pn2_r + m_pp2_r + m_e2_r;

    u4_r     <= u3_r;
    vt4_r    <= vt3_r;
    s4_r     <= snext;
    p4_r     <= pnext;
    fault4_r <= fault3_r || ovf32(64'(s_rnd)) || ovf32(64'(p_rnd));
  end

  dnf_ram #(
    .WIDTH($bits(slot_state_t)),
    .DEPTH(SLOTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_addr),
    .rdata(ram_rdata)
  );

  // stage 4: divisor and operand magnitudes
  assign den   = u4_r + s4_r;
  assign p_mag = p4_r[DATA_W-1] ? DATA_W'(-p4_r) : DATA_W'(p4_r);

  assign push         = vld4_r;
  assign job.num_mag  = {p_mag, 16'd0};
  assign job.den_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign job.q_neg    = p4_r[DATA_W-1] ^ den[DEN_W-1];
  assign job.den_zero = (den == '0);
  assign job.p_neg    = p4_r[DATA_W-1];
  assign job.v        = vt4_r;
  assign job.fault    = fault4_r;

endmodule

### sv/dnf_queue.sv
module dnf_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  dnf_pkg::div_job_t          din,
  input  logic                       pop,
  output dnf_pkg::div_job_t          dout,
  output logic                       empty,
  output logic [dnf_pkg::QCNT_W-1:0] level
);
  import dnf_pkg::*;

  div_job_t mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign level = cnt_r;

endmodule

### sv/dnf_back.sv
module dnf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dnf_pkg::div_job_t                 job,
  input  logic                              q_empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dnf_pkg::DATA_W-1:0] out_field_next,
  output logic                              out_fault
);
  import dnf_pkg::*;

  localparam int STEPS = NUM_W;

  logic                     sv_r  [STEPS+1];
  logic [NUM_W-1:0]         num_r [STEPS+1];
  logic [DEN_W-1:0]         rem_r [STEPS+1];
  logic [DEN_W-1:0]         dm_r  [STEPS+1];
  logic                     qn_r  [STEPS+1];
  logic                     dz_r  [STEPS+1];
  logic                     pn_r  [STEPS+1];
  logic signed [DATA_W-1:0] vv_r  [STEPS+1];
  logic                     ft_r  [STEPS+1];

  logic [NUM_W-1:0] num_nxt [STEPS];
  logic [DEN_W-1:0] rem_nxt [STEPS];
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;

  logic                     pv_r, pdz_r, ppn_r, pft_r;
  logic signed [NUM_W:0]    qs_r;
  logic signed [DATA_W-1:0] pvv_r;
  logic signed [NUM_W+1:0]  res;

  logic out_valid_r, out_fault_r, adv;
  logic signed [DATA_W-1:0] out_field_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_empty;

  // one restoring quotient bit per stage
  always_comb begin
    rem_sh = '0;
    diff   = '0;
    for (int k = 0; k < STEPS; k++) begin
      rem_sh = {rem_r[k], num_r[k][NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dm_r[k]};
      if (!diff[DEN_W+1]) begin
        rem_nxt[k] = diff[DEN_W-1:0];
        num_nxt[k] = {num_r[k][NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = rem_sh[DEN_W-1:0];
        num_nxt[k] = {num_r[k][NUM_W-2:0], 1'b0};
      end
    end
  end

  assign res = (NUM_W+2)'(pvv_r) - (NUM_W+2)'(qs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= STEPS; k++) begin
        sv_r[k] <= 1'b0;
      end
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= pop;
      for (int k = 0; k < STEPS; k++) begin
        sv_r[k+1] <= sv_r[k];
      end
      pv_r        <= sv_r[STEPS];
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r[0] <= job.num_mag;
      rem_r[0] <= '0;
      dm_r[0]  <= job.den_mag;
      qn_r[0]  <= job.q_neg;
      dz_r[0]  <= job.den_zero;
      pn_r[0]  <= job.p_neg;
      vv_r[0]  <= job.v;
      ft_r[0]  <= job.fault;
      for (int k = 0; k < STEPS; k++) begin
        num_r[k+1] <= num_nxt[k];
        rem_r[k+1] <= rem_nxt[k];
        dm_r[k+1]  <= dm_r[k];
        qn_r[k+1]  <= qn_r[k];
        dz_r[k+1]  <= dz_r[k];
        pn_r[k+1]  <= pn_r[k];
        vv_r[k+1]  <= vv_r[k];
        ft_r[k+1]  <= ft_r[k];
      end
      qs_r  <= qn_r[STEPS] ? -$signed({1'b0, num_r[STEPS]}) : $signed({1'b0, num_r[STEPS]});
      pvv_r <= vv_r[STEPS];
      pdz_r <= dz_r[STEPS];
      ppn_r <= pn_r[STEPS];
      pft_r <= ft_r[STEPS];
      if (pdz_r) begin
        out_field_r <= ppn_r ? SAT_MAX : SAT_MIN;
        out_fault_r <= 1'b1;
      end else begin
        out_field_r <= sat32(64'(res));
        out_fault_r <= pft_r || ovf32(64'(res));
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_field_next = out_field_r;
  assign out_fault      = out_fault_r;

endmodule

### sv/drude_nonlinear_field_update.sv
// channel | direction | words carried
// --------+-----------+---------------------------------------------------
// in_     | input     | axis, slot, u_term, v_term, field_now
// out_    | output    | field_next, fault
// cfg_    | input     | coeff_x / coeff_y / coeff_z, write only, no wait
//
// One word per cycle while in_ready is high; path: 4 update stages,
// queue, 48 quotient stages, sign fix and output register.
// After reset a pass over all 4096 slots zeroes the slot memory; in_ready
// stays low meanwhile. A word whose slot is still in the read-update-write
// window of the slot memory waits; a stalled output freezes the quotient
// pipeline and the queue credit then holds in_ready low.
module drude_nonlinear_field_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dnf_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_axis,
  input  logic [11:0]                       in_slot,
  input  logic signed [dnf_pkg::DATA_W-1:0] in_u_term,
  input  logic signed [dnf_pkg::DATA_W-1:0] in_v_term,
  input  logic signed [dnf_pkg::DATA_W-1:0] in_field_now,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dnf_pkg::DATA_W-1:0] out_field_next,
  output logic                              out_fault
);
  import dnf_pkg::*;

  div_job_t push_job, pop_job;
  logic push, pop, q_empty;
  logic [QCNT_W-1:0] q_level;

  dnf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_axis     (in_axis),
    .in_slot     (in_slot),
    .in_u_term   (in_u_term),
    .in_v_term   (in_v_term),
    .in_field_now(in_field_now),
    .q_level     (q_level),
    .push        (push),
    .job         (push_job)
  );

  dnf_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (push_job),
    .pop  (pop),
    .dout (pop_job),
    .empty(q_empty),
    .level(q_level)
  );

  dnf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (pop_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_field_next(out_field_next),
    .out_fault     (out_fault)
  );

endmodule
